[rtl/jtp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to polar: shared package
// Fixed-point formats, CORDIC arctangent table and flag type used by the
// pipeline stages of the joystick to polar converter.
// ----------------------------------------------------------------------------
package jtp_pkg;

    localparam int COORD_BITS_DEF   = 8;

    // Fixed-point formats.
    localparam int XY_FRAC          = 24;   // coordinate scale inside the CORDIC
    localparam int ANG_FRAC         = 20;   // angle accumulator, 2^-20 degree
    localparam int ANGLE_FRAC       = 4;    // reported heading, 1/16 degree
    localparam int ZW               = 30;   // angle accumulator width, signed

    localparam int CORDIC_STEPS     = 24;
    // Square root: 15 result bits from a radicand below 2^30. This must not
    // exceed CORDIC_STEPS, since each root digit is hosted by one CORDIC stage.
    localparam int SQRT_STEPS       = 15;
    localparam int RAD_W            = 2 * SQRT_STEPS;

    localparam int POWER_W          = 15;
    localparam int ANGLE_W          = 14;

    localparam int CLAMP_MAG        = 64;
    localparam int FULL_PERCENT     = 100;
    localparam int QUARTER_TURN_DEG = 90;

    localparam int POWER_FULL       = FULL_PERCENT * 256;
    localparam int CLAMP_SQ         = CLAMP_MAG * CLAMP_MAG;
    localparam int CLAMP_SQ_BITS    = $clog2(CLAMP_SQ);
    localparam int POWER_SCALE      = FULL_PERCENT * 256 / CLAMP_MAG;
    localparam int SCALE_SQ         = POWER_SCALE * POWER_SCALE;

    localparam int ANGLE_MIN        = -QUARTER_TURN_DEG * (1 << ANGLE_FRAC);
    localparam int ANGLE_LIM        = 3 * QUARTER_TURN_DEG * (1 << ANGLE_FRAC);

    localparam logic signed [ZW-1:0] QUARTER_Q20 =
        ZW'(QUARTER_TURN_DEG * (1 << ANG_FRAC));

    // round(atan(2^-i) in degrees * 2^20)
    localparam logic signed [ZW-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    typedef struct packed {
        logic zero;     // both coordinates zero
        logic sat;      // magnitude at or above the clamp
    } t_flags;

endpackage

[rtl/jtp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to polar: channel interfaces
// Valid/ready channels for joystick samples and polar results.
// ----------------------------------------------------------------------------
interface jtp_in_if
    import jtp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] stick_x;
    logic signed [COORD_BITS-1:0] stick_y;

    modport source (output valid, output stick_x, output stick_y, input ready);
    modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

interface jtp_out_if
    import jtp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic        [POWER_W-1:0] power_q8;
    logic signed [ANGLE_W-1:0] angle_q4;

    modport source (output valid, output power_q8, output angle_q4, input ready);
    modport sink   (input valid, input power_q8, input angle_q4, output ready);
endinterface

[rtl/jtp_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to polar: front stages
// Squares and left half plane pre-rotation, then clamp detection and the
// scaled square-root radicand. Two register stages.
// ----------------------------------------------------------------------------
module jtp_prep
    import jtp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int XW = COORD_BITS + XY_FRAC + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_stick_x,
    input  logic signed [COORD_BITS-1:0] i_stick_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_flags                       o_flags,
    output logic signed [XW-1:0]         o_cx,
    output logic signed [XW-1:0]         o_cy,
    output logic signed [ZW-1:0]         o_z,
    output logic        [RAD_W-1:0]      o_rem
);
    localparam int SQW = 2 * COORD_BITS;

    logic                   a_ready;
    logic                   b_ready;

    logic signed [SQW-1:0]  sx;
    logic signed [SQW-1:0]  sy;
    logic signed [SQW-1:0]  sq_x;
    logic signed [SQW-1:0]  sq_y;
    logic signed [XW-1:0]   xe;
    logic signed [XW-1:0]   ye;

    logic                   r_a_valid;
    logic                   r_a_zero;
    logic        [SQW-1:0]  r_a_r2;
    logic signed [XW-1:0]   r_a_x;
    logic signed [XW-1:0]   r_a_y;
    logic signed [ZW-1:0]   r_a_z;
    logic        [SQW-1:0]  n_a_r2;
    logic signed [XW-1:0]   n_a_x;
    logic signed [XW-1:0]   n_a_y;
    logic signed [ZW-1:0]   n_a_z;

    logic                   r_b_valid;
    t_flags                 r_b_flags;
    logic signed [XW-1:0]   r_b_x;
    logic signed [XW-1:0]   r_b_y;
    logic signed [ZW-1:0]   r_b_z;
    logic        [RAD_W-1:0] r_b_n;
    logic        [RAD_W-1:0] n_b_n;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Stage A: squares and quarter-turn pre-rotation into the right half plane.
    always_comb begin
        sx     = SQW'(i_stick_x);
        sy     = SQW'(i_stick_y);
        sq_x   = sx * sx;
        sq_y   = sy * sy;
        n_a_r2 = $unsigned(sq_x) + $unsigned(sq_y);
        xe     = XW'(i_stick_x);
        ye     = XW'(i_stick_y);
        if (i_stick_x[COORD_BITS-1]) begin
            if (!i_stick_y[COORD_BITS-1]) begin
                n_a_x = ye <<< XY_FRAC;
                n_a_y = (-xe) <<< XY_FRAC;
                n_a_z = QUARTER_Q20;
            end else begin
                n_a_x = (-ye) <<< XY_FRAC;
                n_a_y = xe <<< XY_FRAC;
                n_a_z = -QUARTER_Q20;
            end
        end else begin
            n_a_x = xe <<< XY_FRAC;
            n_a_y = ye <<< XY_FRAC;
            n_a_z = '0;
        end
    end

    // Stage B: below the clamp the squared radius fits in CLAMP_SQ_BITS bits.
    assign n_b_n = RAD_W'(r_a_r2[CLAMP_SQ_BITS-1:0]) * RAD_W'(SCALE_SQ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
        if (a_ready && i_valid) begin
            r_a_zero <= (i_stick_x == '0) && (i_stick_y == '0);
            r_a_r2   <= n_a_r2;
            r_a_x    <= n_a_x;
            r_a_y    <= n_a_y;
            r_a_z    <= n_a_z;
        end
        if (b_ready && r_a_valid) begin
            r_b_flags.zero <= r_a_zero;
            r_b_flags.sat  <= r_a_r2 >= SQW'(CLAMP_SQ);
            r_b_x          <= r_a_x;
            r_b_y          <= r_a_y;
            r_b_z          <= r_a_z;
            r_b_n          <= n_b_n;
        end
    end

    assign o_valid = r_b_valid;
    assign o_flags = r_b_flags;
    assign o_cx    = r_b_x;
    assign o_cy    = r_b_y;
    assign o_z     = r_b_z;
    assign o_rem   = r_b_n;

endmodule

[rtl/jtp_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to polar: CORDIC stage
// One vectoring CORDIC rotation and, in the early stages, one digit of the
// restoring square root. One register stage.
// ----------------------------------------------------------------------------
module jtp_stage
    import jtp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int STAGE      = 0,
    localparam int XW = COORD_BITS + XY_FRAC + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_flags                  i_flags,
    input  logic signed [XW-1:0]    i_cx,
    input  logic signed [XW-1:0]    i_cy,
    input  logic signed [ZW-1:0]    i_z,
    input  logic        [RAD_W-1:0] i_rem,
    input  logic        [RAD_W-1:0] i_root,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_flags                  o_flags,
    output logic signed [XW-1:0]    o_cx,
    output logic signed [XW-1:0]    o_cy,
    output logic signed [ZW-1:0]    o_z,
    output logic        [RAD_W-1:0] o_rem,
    output logic        [RAD_W-1:0] o_root
);
    logic signed [XW-1:0]    dx;
    logic signed [XW-1:0]    dy;
    logic signed [XW-1:0]    n_cx;
    logic signed [XW-1:0]    n_cy;
    logic signed [ZW-1:0]    n_z;
    logic        [RAD_W-1:0] n_rem;
    logic        [RAD_W-1:0] n_root;

    logic                    r_valid;
    t_flags                  r_flags;
    logic signed [XW-1:0]    r_cx;
    logic signed [XW-1:0]    r_cy;
    logic signed [ZW-1:0]    r_z;
    logic        [RAD_W-1:0] r_rem;
    logic        [RAD_W-1:0] r_root;

    assign o_ready = !r_valid || i_ready;

    // Drive y toward zero; both updates use the old x and y.
    always_comb begin
        dx = i_cy >>> STAGE;
        dy = i_cx >>> STAGE;
        if (!i_cy[XW-1]) begin
            n_cx = i_cx + dx;
            n_cy = i_cy - dy;
            n_z  = i_z + ATAN_Q20[STAGE];
        end else begin
            n_cx = i_cx - dx;
            n_cy = i_cy + dy;
            n_z  = i_z - ATAN_Q20[STAGE];
        end
    end

    if (STAGE < SQRT_STEPS) begin : g_sqrt
        localparam logic [RAD_W-1:0] SQ_BIT = RAD_W'(1) << (RAD_W - 2 - 2 * STAGE);
        logic [RAD_W:0] trial;

        always_comb begin
            trial = {1'b0, i_root} + {1'b0, SQ_BIT};
            if ({1'b0, i_rem} >= trial) begin
                n_rem  = i_rem - trial[RAD_W-1:0];
                n_root = (i_root >> 1) + SQ_BIT;
            end else begin
                n_rem  = i_rem;
                n_root = i_root >> 1;
            end
        end
    end else begin : g_pass
        assign n_rem  = i_rem;
        assign n_root = i_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_flags <= i_flags;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_z     <= n_z;
            r_rem   <= n_rem;
            r_root  <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_z     = r_z;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

[rtl/jtp_post.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to polar: output stage
// Rounds the root and the heading, applies the clamp and the origin case,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module jtp_post
    import jtp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_flags                    i_flags,
    input  logic signed [ZW-1:0]      i_z,
    input  logic        [RAD_W-1:0]   i_rem,
    input  logic        [RAD_W-1:0]   i_root,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic        [POWER_W-1:0] o_power_q8,
    output logic signed [ANGLE_W-1:0] o_angle_q4
);
    localparam int HW = ZW + 1;
    localparam int ASH = ANG_FRAC - ANGLE_FRAC;
    localparam logic signed [HW-1:0] ROUND_HALF = HW'(1 << (ASH - 1));

    logic signed [HW-1:0]      heading;
    logic signed [HW-1:0]      q_full;
    logic                      round_up;
    logic        [POWER_W-1:0] n_power;
    logic signed [ANGLE_W-1:0] n_angle;

    logic                      r_valid;
    logic        [POWER_W-1:0] r_power;
    logic signed [ANGLE_W-1:0] r_angle;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        heading  = HW'(QUARTER_Q20) - HW'(i_z);
        q_full   = (heading + ROUND_HALF) >>> ASH;
        // Remainder above the root means the true root lies past the midpoint.
        round_up = i_rem > i_root;
        if (i_flags.sat) begin
            n_power = POWER_W'(POWER_FULL);
        end else begin
            n_power = i_root[POWER_W-1:0] + POWER_W'(round_up);
        end
        if (i_flags.zero) begin
            n_angle = '0;
        end else begin
            n_angle = q_full[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_power <= n_power;
            r_angle <= n_angle;
        end
    end

    assign o_valid    = r_valid;
    assign o_power_q8 = r_power;
    assign o_angle_q4 = r_angle;

endmodule

[rtl/joystick_to_polar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to polar converter
// Turns a signed joystick sample into a clamped power percentage and a
// compass-style heading through a fully pipelined CORDIC and square root.
// ----------------------------------------------------------------------------
//
//   Channel   Port    Direction  Payload
//   -------   -----   ---------  ------------------------------------------
//   sample    i_in    sink       stick_x, stick_y (COORD_BITS, signed)
//   result    o_out   source     power_q8 (15, unsigned), angle_q4 (14, signed)
//
// Every accepted request produces exactly one result after it has passed the
// two front stages, the 24 CORDIC stages and the output register.
// A new request is taken every cycle unless the output stalls; the rate is set
// by the single-rotation CORDIC stages, each holding one request in flight.
// Reset clears only the valid bits of the stages, not the data registers.
// Each stage loads when it is empty or when its successor moves on or is empty,
// and holds otherwise, so bubbles close up under a stalled output and no
// request is dropped or duplicated.
//
// Power is round(400 * sqrt(x^2 + y^2)) in 1/256 percent, saturating at 25600
// once the magnitude reaches 64. The root is found digit by digit, one digit
// in each of the first 15 CORDIC stages, and rounded from the final
// remainder. The heading is 90 degrees minus atan2(y, x) in 1/16 degree, so
// up reads 0 and clockwise is positive; the origin reads 0.
// ----------------------------------------------------------------------------
module joystick_to_polar
    import jtp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jtp_in_if.sink        i_in,
    jtp_out_if.source     o_out
);
    localparam int XW = COORD_BITS + XY_FRAC + 3;

    // Index k carries the request entering CORDIC stage k; the last index
    // feeds the output stage.
    logic                    w_valid [CORDIC_STEPS+1];
    logic                    w_ready [CORDIC_STEPS+1];
    t_flags                  w_flags [CORDIC_STEPS+1];
    logic signed [XW-1:0]    w_cx    [CORDIC_STEPS+1];
    logic signed [XW-1:0]    w_cy    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    w_z     [CORDIC_STEPS+1];
    logic        [RAD_W-1:0] w_rem   [CORDIC_STEPS+1];
    logic        [RAD_W-1:0] w_root  [CORDIC_STEPS+1];

    jtp_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_stick_x (i_in.stick_x),
        .i_stick_y (i_in.stick_y),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_flags   (w_flags[0]),
        .o_cx      (w_cx[0]),
        .o_cy      (w_cy[0]),
        .o_z       (w_z[0]),
        .o_rem     (w_rem[0])
    );

    // The root accumulator starts empty.
    assign w_root[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
        jtp_stage #(
            .COORD_BITS (COORD_BITS),
            .STAGE      (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_flags (w_flags[k]),
            .i_cx    (w_cx[k]),
            .i_cy    (w_cy[k]),
            .i_z     (w_z[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_flags (w_flags[k+1]),
            .o_cx    (w_cx[k+1]),
            .o_cy    (w_cy[k+1]),
            .o_z     (w_z[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1])
        );
    end

    jtp_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[CORDIC_STEPS]),
        .o_ready    (w_ready[CORDIC_STEPS]),
        .i_flags    (w_flags[CORDIC_STEPS]),
        .i_z        (w_z[CORDIC_STEPS]),
        .i_rem      (w_rem[CORDIC_STEPS]),
        .i_root     (w_root[CORDIC_STEPS]),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_power_q8 (o_out.power_q8),
        .o_angle_q4 (o_out.angle_q4)
    );

`ifndef NO_ASSERTIONS
    // The reported power never exceeds the full-scale percentage.
    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.power_q8 <= POWER_W'(POWER_FULL)))
        else $error("power beyond full scale");

    // The heading stays within a quarter turn left of up to just under
    // three quarter turns right.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.angle_q4 >= ANGLE_MIN && o_out.angle_q4 < ANGLE_LIM))
        else $error("heading out of range");

    // A sample at the origin reaches the output stage with an empty root.
    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[CORDIC_STEPS] && w_flags[CORDIC_STEPS].zero) |->
            (w_root[CORDIC_STEPS] == '0 && w_rem[CORDIC_STEPS] == '0))
        else $error("origin sample with nonzero root");

    // A clamped sample always reports exactly full scale.
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[CORDIC_STEPS] && w_ready[CORDIC_STEPS] && w_flags[CORDIC_STEPS].sat)
            |=> (o_out.power_q8 == POWER_W'(POWER_FULL)))
        else $error("clamped sample not at full scale");
`endif

endmodule

[test/tb_joystick_to_polar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick to polar converter testbench
// Sends joystick samples through the sample channel and checks every result
// for power and heading against a bit-exact behavioral model of the integer
// root and the vectoring CORDIC. Stimulus is a directed corner set followed
// by random sweeps under bursty input traffic and several output stall
// patterns, including a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_joystick_to_polar
    import jtp_pkg::*;
();

    localparam int COORD_BITS     = 8;
    localparam int MAG_LIMIT      = 64;
    localparam int POWER_MAX      = 25600;
    // 400 = 100 percent * 256 / 64: power is round(sqrt(400^2 * r^2)).
    localparam int POWER_GAIN     = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    // Output stall patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_STREAM,      // always ready
        RX_RANDOM,      // ready drawn at random
        RX_PATTERN      // stalled in a repeating pattern
    } t_rx_mode;

    typedef struct packed {
        logic        [POWER_W-1:0] power_q8;
        logic signed [ANGLE_W-1:0] angle_q4;
    } t_polar;

    logic i_clk;
    logic i_rst_n;

    jtp_in_if #(.COORD_BITS(COORD_BITS)) sample_ch ();
    jtp_out_if                           result_ch ();

    joystick_to_polar #(
        .COORD_BITS (COORD_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (result_ch)
    );

    // Predicted results, oldest first, one per accepted request.
    t_polar   expected_polar[$];
    int       mismatches    = 0;
    int       idle_cycles   = 0;

    // Sender pacing: bursts of random length separated by random gaps.
    bit       pace_gaps     = 1'b0;
    int       burst_left    = 0;

    // Receiver control. A long hold-off is asked for by bumping
    // hold_requests; the receiver counts the stalled cycles itself.
    t_rx_mode rx_mode       = RX_STREAM;
    int       hold_requests = 0;
    int       holds_served  = 0;
    int       hold_left     = 0;
    int       rx_cycle      = 0;

    // Arctangent of 2^-i in units of 2^-20 degree, rounded to nearest.
    longint   atan_step_q20 [0:23] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    // Clock: 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Behavioral model of one conversion. Power comes from an exact integer
    // square root rounded to nearest; the heading comes from a vectoring
    // CORDIC with coordinates scaled by 2^24 and angles in 2^-20 degree.
    function automatic t_polar predict_polar(input logic signed [COORD_BITS-1:0] sx,
                                             input logic signed [COORD_BITS-1:0] sy);
        longint x, y, r2, radicand, rem, root, probe;
        longint cx, cy, z, dx, dy, heading, q;
        t_polar res;
        x = sx;
        y = sy;
        r2 = x * x + y * y;

        if (r2 >= MAG_LIMIT * MAG_LIMIT) begin
            res.power_q8 = POWER_W'(POWER_MAX);
        end else begin
            // Digit-by-digit root; the radicand stays below 2^30.
            radicand = longint'(POWER_GAIN) * POWER_GAIN * r2;
            rem      = radicand;
            root     = 0;
            probe    = longint'(1) << 30;
            while (probe > rem) probe = probe >> 2;
            while (probe != 0) begin
                if (rem >= root + probe) begin
                    rem  = rem - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            if (radicand > root * root + root) root = root + 1;
            res.power_q8 = POWER_W'(root);
        end

        if (x == 0 && y == 0) begin
            res.angle_q4 = '0;
        end else begin
            cx = x <<< 24;
            cy = y <<< 24;
            z  = 0;
            // Fold the left half plane onto the right one by a quarter turn.
            if (cx < 0) begin
                dx = cx;
                if (cy >= 0) begin
                    cx = cy;
                    cy = -dx;
                    z  = longint'(90) <<< 20;
                end else begin
                    cx = -cy;
                    cy = dx;
                    z  = -(longint'(90) <<< 20);
                end
            end
            for (int i = 0; i < 24; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z  = z + atan_step_q20[i];
                end else begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z  = z - atan_step_q20[i];
                end
            end
            // Heading is 90 degrees minus the angle, rounded to 1/16 degree.
            heading      = (longint'(90) <<< 20) - z;
            q            = (heading + (longint'(1) <<< 15)) >>> 16;
            res.angle_q4 = ANGLE_W'(q);
        end
        return res;
    endfunction

    // Offers one sample and returns at the rising edge where it is taken.
    // The valid stays high afterwards so that back-to-back requests need no
    // toggling; whoever idles the sender lowers it at the next falling edge.
    task automatic offer_sample(input logic signed [COORD_BITS-1:0] x,
                                input logic signed [COORD_BITS-1:0] y);
        int gap;
        if (pace_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 8);
                @(negedge i_clk);
                sample_ch.valid   = 1'b0;
                sample_ch.stick_x = COORD_BITS'($urandom);
                sample_ch.stick_y = COORD_BITS'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left--;
        end
        @(negedge i_clk);
        sample_ch.valid   = 1'b1;
        sample_ch.stick_x = x;
        sample_ch.stick_y = y;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        expected_polar.push_back(predict_polar(x, y));
    endtask

    // Idles the sender and waits until every predicted result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        sample_ch.valid = 1'b0;
        while (expected_polar.size() != 0) @(posedge i_clk);
    endtask

    // Corners: origin, the axes in both directions including the negative
    // x axis where the heading is -90, the diagonals, the extreme codes of
    // both fields, and magnitudes right below and right at the clamp.
    task automatic test_corners();
        pace_gaps = 1'b0;
        rx_mode   = RX_STREAM;
        offer_sample(0, 0);
        offer_sample(1, 0);
        offer_sample(-1, 0);
        offer_sample(0, 1);
        offer_sample(0, -1);
        offer_sample(-1, -1);
        offer_sample(127, 0);
        offer_sample(-128, 0);
        offer_sample(0, 127);
        offer_sample(0, -128);
        offer_sample(127, 127);
        offer_sample(-128, -128);
        offer_sample(-128, 127);
        offer_sample(127, -128);
        offer_sample(63, 0);
        offer_sample(64, 0);
        offer_sample(-64, 0);
        offer_sample(0, -63);
        offer_sample(45, 45);
        offer_sample(46, 45);
        offer_sample(-45, -45);
        offer_sample(-37, 52);
        wait_drained();
    endtask

    // Full-range random samples under bursty input and random output stalls.
    task automatic test_random_full_range();
        pace_gaps = 1'b1;
        rx_mode   = RX_RANDOM;
        repeat (400) offer_sample(COORD_BITS'($urandom), COORD_BITS'($urandom));
        wait_drained();
    endtask

    // Samples mostly inside the clamp circle so the rounded root is exercised.
    task automatic test_random_unclamped();
        pace_gaps = 1'b1;
        rx_mode   = RX_PATTERN;
        repeat (250) begin
            offer_sample(COORD_BITS'(int'($urandom_range(0, 140)) - 70),
                         COORD_BITS'(int'($urandom_range(0, 140)) - 70));
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the pipeline fills and stalls its input.
    task automatic test_output_hold_off();
        pace_gaps = 1'b0;
        rx_mode   = RX_STREAM;
        hold_requests++;
        repeat (120) offer_sample(COORD_BITS'($urandom), COORD_BITS'($urandom));
        wait_drained();
    endtask

    // Short bursts, each followed by a pause until the pipeline is empty.
    task automatic test_burst_and_drain();
        int len;
        pace_gaps = 1'b0;
        rx_mode   = RX_RANDOM;
        repeat (8) begin
            len = $urandom_range(1, 15);
            repeat (len) offer_sample(COORD_BITS'($urandom), COORD_BITS'($urandom));
            wait_drained();
        end
    endtask

    // Full rate on both sides with no idling at all.
    task automatic test_full_rate();
        pace_gaps = 1'b0;
        rx_mode   = RX_STREAM;
        repeat (150) offer_sample(COORD_BITS'($urandom), COORD_BITS'($urandom));
        wait_drained();
    endtask

    // Receiver: drives ready at the falling edge according to the current
    // stall pattern, with a long counted hold-off whenever one is asked for.
    always @(negedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left       = hold_left - 1;
            result_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STREAM:  result_ch.ready <= 1'b1;
                RX_RANDOM:  result_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: result_ch.ready <= ((rx_cycle % 11) >= 3);
                default:    result_ch.ready <= 1'b1;
            endcase
        end
    end

    // Result checker: each accepted result is matched against the oldest
    // prediction. A result with nothing predicted is a failure as well.
    always @(posedge i_clk) begin
        t_polar exp_res;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_polar.size() == 0) begin
                $error("unexpected result: power_q8 %0d, angle_q4 %0d",
                       result_ch.power_q8, result_ch.angle_q4);
                mismatches++;
            end else begin
                exp_res = expected_polar.pop_front();
                if (result_ch.power_q8 !== exp_res.power_q8) begin
                    $error("power_q8 mismatch: expected %0d, actual %0d",
                           exp_res.power_q8, result_ch.power_q8);
                    mismatches++;
                end
                if (result_ch.angle_q4 !== exp_res.angle_q4) begin
                    $error("angle_q4 mismatch: expected %0d, actual %0d",
                           exp_res.angle_q4, result_ch.angle_q4);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no request moves on either channel for
    // far longer than the longest stall that a correct block can show.
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Sequencer: reset first, then the tests in turn, then a
    // drain of the pipeline so that any stray result is still caught.
    initial begin
        i_rst_n           = 1'b0;
        sample_ch.valid   = 1'b0;
        sample_ch.stick_x = '0;
        sample_ch.stick_y = '0;
        result_ch.ready   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corners();
        test_random_full_range();
        test_random_unclamped();
        test_output_hold_off();
        test_burst_and_drain();
        test_full_rate();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
